### src/assert_macros.svh
// Assertion helpers for the RTL, included by heartbeat_membership_table.sv.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// prop must hold at every rising clock edge outside reset
`define HMT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// cond must never be true outside reset
`define HMT_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define HMT_ASSERT(lbl, prop, msg)
`define HMT_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

### src/hmt_pkg.sv
`default_nettype none

package hmt_pkg;

    localparam int TABLE_DEPTH_DEF = 32;

    localparam int ID_W    = 32;
    localparam int PORT_W  = 16;
    localparam int HB_W    = 32;
    localparam int TICK_W  = 32;
    localparam int TOUT_W  = 16;
    localparam int EV_W    = 3;
    localparam int CNT_OUT_W = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam logic [EV_W-1:0] EV_REFRESH = 3'd0;
    localparam logic [EV_W-1:0] EV_OLDER   = 3'd1;
    localparam logic [EV_W-1:0] EV_ADDED   = 3'd2;
    localparam logic [EV_W-1:0] EV_FULL    = 3'd3;
    localparam logic [EV_W-1:0] EV_REMOVED = 3'd4;
    localparam logic [EV_W-1:0] EV_TICK    = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_SELF_ID   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SELF_PORT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 2'd3;

    localparam logic [ID_W-1:0]   SELF_ID_RST   = 32'd1;
    localparam logic [PORT_W-1:0] SELF_PORT_RST = 16'd0;
    localparam logic [TOUT_W-1:0] TIMEOUT_RST   = 16'd20;
    localparam logic [TOUT_W-1:0] PERIOD_RST    = 16'd5;

    // request walking down the cell chain
    typedef struct packed {
        logic              active;
        logic              cmd;
        logic [ID_W-1:0]   id;
        logic [PORT_W-1:0] port;
        logic [HB_W-1:0]   hb;
        logic              found;
        logic [EV_W-1:0]   ev;
        logic [HB_W-1:0]   hb_res;
        logic              free_seen;
    } probe_t;

    // values broadcast to every cell
    typedef struct packed {
        logic [TICK_W-1:0] cur_tick;
        logic [TOUT_W-1:0] timeout;
    } ctx_t;

    // direct entry write
    typedef struct packed {
        logic              idport;
        logic              hbst;
        logic [ID_W-1:0]   id;
        logic [PORT_W-1:0] port;
        logic [HB_W-1:0]   hb;
        logic [TICK_W-1:0] stamp;
    } load_t;

endpackage

`default_nettype wire

### src/hmt_cell.sv
`default_nettype none

module hmt_cell #(
    parameter int CNT_W = 6
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       pinned,
    input  wire hmt_pkg::ctx_t              ctx,
    input  wire hmt_pkg::load_t             load,
    input  wire hmt_pkg::probe_t            probe_in,
    input  wire logic [CNT_W-1:0]           cnt_in,
    output hmt_pkg::probe_t                 probe_out,
    output logic [CNT_W-1:0]                cnt_out,
    output logic                            valid,
    output logic                            claim,
    output logic                            rm_pending,
    output logic [hmt_pkg::ID_W-1:0]        id,
    output logic [hmt_pkg::PORT_W-1:0]      port,
    output logic [hmt_pkg::HB_W-1:0]        hb
);

    logic                        valid_reg, valid_next;
    logic                        claim_reg, claim_next;
    logic                        rm_reg, rm_next;
    logic [hmt_pkg::ID_W-1:0]    id_reg, id_next;
    logic [hmt_pkg::PORT_W-1:0]  port_reg, port_next;
    logic [hmt_pkg::HB_W-1:0]    hb_reg, hb_next;
    logic [hmt_pkg::TICK_W-1:0]  stamp_reg, stamp_next;
    hmt_pkg::probe_t             probe_reg, probe_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;

    logic match, newer, stale, freehit, load_en;
    logic [hmt_pkg::TICK_W-1:0] age;

    always_comb
    begin
        age     = ctx.cur_tick - stamp_reg;
        match   = probe_in.active && (probe_in.cmd == hmt_pkg::CMD_UPDATE) && valid_reg &&
                  (id_reg == probe_in.id) && (port_reg == probe_in.port) && !probe_in.found;
        newer   = hb_reg < probe_in.hb;
        stale   = probe_in.active && (probe_in.cmd == hmt_pkg::CMD_TICK) && valid_reg &&
                  !pinned && (age > {16'd0, ctx.timeout});
        freehit = probe_in.active && (probe_in.cmd == hmt_pkg::CMD_UPDATE) && !valid_reg &&
                  !pinned && !probe_in.free_seen;
        // the self slot takes loads directly, others only once claimed for an add
        load_en = pinned || claim_reg;

        probe_next = probe_in;
        if (match)
        begin
            probe_next.found  = 1'b1;
            probe_next.ev     = newer ? hmt_pkg::EV_REFRESH : hmt_pkg::EV_OLDER;
            probe_next.hb_res = newer ? probe_in.hb : hb_reg;
        end
        if (freehit)
        begin
            probe_next.free_seen = 1'b1;
        end
        cnt_next = cnt_in + CNT_W'(valid_reg && !stale);

        valid_next = valid_reg;
        id_next    = id_reg;
        port_next  = port_reg;
        hb_next    = hb_reg;
        stamp_next = stamp_reg;
        if (stale)
        begin
            valid_next = 1'b0;
        end
        else if (load_en && load.idport)
        begin
            valid_next = 1'b1;
        end
        if (load_en && load.idport)
        begin
            id_next   = load.id;
            port_next = load.port;
        end
        if (match && newer)
        begin
            hb_next    = probe_in.hb;
            stamp_next = ctx.cur_tick;
        end
        else if (load_en && load.hbst)
        begin
            hb_next    = load.hb;
            stamp_next = load.stamp;
        end

        claim_next = probe_in.active ? freehit : claim_reg;
        rm_next    = probe_in.active ? stale : rm_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= pinned;
            claim_reg <= 1'b0;
            rm_reg    <= 1'b0;
            id_reg    <= hmt_pkg::SELF_ID_RST;
            port_reg  <= hmt_pkg::SELF_PORT_RST;
            hb_reg    <= '0;
            stamp_reg <= '0;
            probe_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            claim_reg <= claim_next;
            rm_reg    <= rm_next;
            id_reg    <= id_next;
            port_reg  <= port_next;
            hb_reg    <= hb_next;
            stamp_reg <= stamp_next;
            probe_reg <= probe_in.active ? probe_next : '0;
            cnt_reg   <= cnt_next;
        end
    end

    assign probe_out  = probe_reg;
    assign cnt_out    = cnt_reg;
    assign valid      = valid_reg;
    assign claim      = claim_reg;
    assign rm_pending = rm_reg;
    assign id         = id_reg;
    assign port       = port_reg;
    assign hb         = hb_reg;

endmodule

`default_nettype wire

### src/heartbeat_membership_table.sv
// Flow: a request walks the cell chain, one slot per cycle, into res_reg; an update
// result goes to the output register in FIN once the output is free. A tick first
// scans slots 1 and up, one per cycle unless a removal waits on a busy output, then FIN.
// Only one request is in flight: a new one is taken only once the last one's final
// output is registered and the table is idle again.
// Reset (async, rst_n low): only slot 0 valid, id 1, port 0; tick, heartbeat zero.
`default_nettype none

module heartbeat_membership_table #(
    parameter int TABLE_DEPTH = hmt_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [hmt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [hmt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // member_id [31:0], member_port [47:32], heartbeat [79:48]
    input  wire logic [79:0]                      s_tdata,
    // command [0]
    input  wire logic [0:0]                       s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // member_id_res [31:0], member_port_res [47:32], heartbeat_res [79:48],
    // member_count [85:80], gossip_due [86], zero [87]
    output logic [87:0]                           m_tdata,
    // event_res [2:0]
    output logic [2:0]                            m_tuser,
    output logic                                  m_tlast
);

`include "assert_macros.svh"

    localparam int IW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [IW-1:0] SCAN_FIRST = IW'(1);
    localparam logic [IW-1:0] SCAN_LAST  = IW'(TABLE_DEPTH - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PASS = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0] state_reg, state_next;

    logic [hmt_pkg::ID_W-1:0]    self_id_reg, self_id_next;
    logic [hmt_pkg::PORT_W-1:0]  self_port_reg, self_port_next;
    logic [hmt_pkg::TOUT_W-1:0]  timeout_reg, timeout_next;
    logic [hmt_pkg::TOUT_W-1:0]  period_reg, period_next;
    logic [hmt_pkg::TICK_W-1:0]  tick_reg, tick_next;
    logic [hmt_pkg::HB_W-1:0]    own_hb_reg, own_hb_next;
    logic [hmt_pkg::TOUT_W-1:0]  cd_reg, cd_next;

    hmt_pkg::probe_t   head_reg, head_next;
    hmt_pkg::probe_t   res_reg, res_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [IW-1:0]     sidx_reg, sidx_next;

    logic                        out_valid_reg, out_valid_next;
    logic [hmt_pkg::EV_W-1:0]    out_ev_reg, out_ev_next;
    logic [hmt_pkg::ID_W-1:0]    out_id_reg, out_id_next;
    logic [hmt_pkg::PORT_W-1:0]  out_port_reg, out_port_next;
    logic [hmt_pkg::HB_W-1:0]    out_hb_reg, out_hb_next;
    logic [CNT_W-1:0]            out_cnt_reg, out_cnt_next;
    logic                        out_due_reg, out_due_next;
    logic                        out_last_reg, out_last_next;

    hmt_pkg::probe_t  probe_link [TABLE_DEPTH+1];
    logic [CNT_W-1:0] cnt_link [TABLE_DEPTH+1];
    logic [TABLE_DEPTH-1:0] valid_vec, claim_vec, rm_vec;
    logic [hmt_pkg::ID_W-1:0]   ent_id   [TABLE_DEPTH];
    logic [hmt_pkg::PORT_W-1:0] ent_port [TABLE_DEPTH];
    logic [hmt_pkg::HB_W-1:0]   ent_hb   [TABLE_DEPTH];

    hmt_pkg::ctx_t   ctx;
    hmt_pkg::load_t  load_self, load_add;
    hmt_pkg::probe_t tail;
    logic accept, out_free, add_commit, pend, scan_emit, scan_step, fin_emit, due;
    logic [CNT_W+5:0] cnt_ext;

    assign probe_link[0] = head_reg;
    assign cnt_link[0]   = '0;
    assign tail          = probe_link[TABLE_DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            hmt_cell #(
                .CNT_W (CNT_W)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .pinned     ((gi == 0) ? 1'b1 : 1'b0),
                .ctx        (ctx),
                .load       ((gi == 0) ? load_self : load_add),
                .probe_in   (probe_link[gi]),
                .cnt_in     (cnt_link[gi]),
                .probe_out  (probe_link[gi+1]),
                .cnt_out    (cnt_link[gi+1]),
                .valid      (valid_vec[gi]),
                .claim      (claim_vec[gi]),
                .rm_pending (rm_vec[gi]),
                .id         (ent_id[gi]),
                .port       (ent_port[gi]),
                .hb         (ent_hb[gi])
            );
        end
    endgenerate

    always_comb
    begin
        accept   = s_tvalid && s_tready;
        out_free = !out_valid_reg || m_tready;

        ctx.cur_tick = tick_reg;
        ctx.timeout  = timeout_reg;

        // self slot: identity from configuration, heartbeat and stamp on each tick
        load_self.idport = cfg_we &&
                           ((cfg_index == hmt_pkg::CFG_SELF_ID) ||
                            (cfg_index == hmt_pkg::CFG_SELF_PORT));
        load_self.id     = (cfg_we && (cfg_index == hmt_pkg::CFG_SELF_ID)) ?
                           cfg_wdata : self_id_reg;
        load_self.port   = (cfg_we && (cfg_index == hmt_pkg::CFG_SELF_PORT)) ?
                           cfg_wdata[hmt_pkg::PORT_W-1:0] : self_port_reg;
        load_self.hbst   = accept && (s_tuser[0] == hmt_pkg::CMD_TICK);
        load_self.hb     = own_hb_reg + 32'd1;
        load_self.stamp  = tick_reg + 32'd1;

        add_commit = (state_reg == ST_FIN) && (res_reg.cmd == hmt_pkg::CMD_UPDATE) &&
                     !res_reg.found && res_reg.free_seen && out_free;
        load_add.idport = add_commit;
        load_add.hbst   = add_commit;
        load_add.id     = res_reg.id;
        load_add.port   = res_reg.port;
        load_add.hb     = res_reg.hb;
        load_add.stamp  = tick_reg;

        pend      = rm_vec[sidx_reg];
        scan_emit = (state_reg == ST_SCAN) && pend && out_free;
        scan_step = (state_reg == ST_SCAN) && (!pend || out_free);
        fin_emit  = (state_reg == ST_FIN) && out_free;
        due       = cd_reg <= 16'd1;
    end

    always_comb
    begin
        state_next     = state_reg;
        self_id_next   = self_id_reg;
        self_port_next = self_port_reg;
        timeout_next   = timeout_reg;
        period_next    = period_reg;
        tick_next      = tick_reg;
        own_hb_next    = own_hb_reg;
        cd_next        = cd_reg;
        res_next       = res_reg;
        cnt_next       = cnt_reg;
        sidx_next      = sidx_reg;

        head_next           = '0;
        head_next.active    = accept;
        head_next.cmd       = s_tuser[0];
        head_next.id        = s_tdata[31:0];
        head_next.port      = s_tdata[47:32];
        head_next.hb        = s_tdata[79:48];

        if (cfg_we)
        begin
            unique case (cfg_index)
                hmt_pkg::CFG_SELF_ID:   self_id_next   = cfg_wdata;
                hmt_pkg::CFG_SELF_PORT: self_port_next = cfg_wdata[hmt_pkg::PORT_W-1:0];
                hmt_pkg::CFG_TIMEOUT:   timeout_next   = cfg_wdata[hmt_pkg::TOUT_W-1:0];
                hmt_pkg::CFG_PERIOD:    period_next    = cfg_wdata[hmt_pkg::TOUT_W-1:0];
                default: ;
            endcase
        end

        if (load_self.hbst)
        begin
            tick_next   = tick_reg + 32'd1;
            own_hb_next = own_hb_reg + 32'd1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_PASS;
                end
            end
            ST_PASS:
            begin
                if (tail.active)
                begin
                    res_next   = tail;
                    cnt_next   = cnt_link[TABLE_DEPTH];
                    sidx_next  = SCAN_FIRST;
                    state_next = (tail.cmd == hmt_pkg::CMD_TICK) ? ST_SCAN : ST_FIN;
                end
            end
            ST_SCAN:
            begin
                if (scan_step)
                begin
                    if (sidx_reg == SCAN_LAST)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        sidx_next = sidx_reg + IW'(1);
                    end
                end
            end
            ST_FIN:
            begin
                if (fin_emit)
                begin
                    state_next = ST_IDLE;
                    if (res_reg.cmd == hmt_pkg::CMD_TICK)
                    begin
                        cd_next = due ? period_reg : cd_reg - 16'd1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        out_ev_next    = out_ev_reg;
        out_id_next    = out_id_reg;
        out_port_next  = out_port_reg;
        out_hb_next    = out_hb_reg;
        out_cnt_next   = out_cnt_reg;
        out_due_next   = out_due_reg;
        out_last_next  = out_last_reg;

        if (scan_emit)
        begin
            out_valid_next = 1'b1;
            out_ev_next    = hmt_pkg::EV_REMOVED;
            out_id_next    = ent_id[sidx_reg];
            out_port_next  = ent_port[sidx_reg];
            out_hb_next    = ent_hb[sidx_reg];
            out_cnt_next   = cnt_reg;
            out_due_next   = 1'b0;
            out_last_next  = 1'b0;
        end
        else if (fin_emit)
        begin
            out_valid_next = 1'b1;
            out_cnt_next   = cnt_reg;
            out_due_next   = 1'b0;
            out_last_next  = 1'b1;
            out_id_next    = res_reg.id;
            out_port_next  = res_reg.port;
            priority if (res_reg.cmd == hmt_pkg::CMD_TICK)
            begin
                out_ev_next   = hmt_pkg::EV_TICK;
                out_id_next   = self_id_reg;
                out_port_next = self_port_reg;
                out_hb_next   = own_hb_reg;
                out_due_next  = due;
            end
            else if (res_reg.found)
            begin
                out_ev_next = res_reg.ev;
                out_hb_next = res_reg.hb_res;
            end
            else if (res_reg.free_seen)
            begin
                out_ev_next  = hmt_pkg::EV_ADDED;
                out_hb_next  = res_reg.hb;
                out_cnt_next = cnt_reg + CNT_W'(1);
            end
            else
            begin
                out_ev_next = hmt_pkg::EV_FULL;
                out_hb_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            self_id_reg   <= hmt_pkg::SELF_ID_RST;
            self_port_reg <= hmt_pkg::SELF_PORT_RST;
            timeout_reg   <= hmt_pkg::TIMEOUT_RST;
            period_reg    <= hmt_pkg::PERIOD_RST;
            tick_reg      <= '0;
            own_hb_reg    <= '0;
            cd_reg        <= hmt_pkg::PERIOD_RST;
            head_reg      <= '0;
            sidx_reg      <= SCAN_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            self_id_reg   <= self_id_next;
            self_port_reg <= self_port_next;
            timeout_reg   <= timeout_next;
            period_reg    <= period_next;
            tick_reg      <= tick_next;
            own_hb_reg    <= own_hb_next;
            cd_reg        <= cd_next;
            head_reg      <= head_next;
            sidx_reg      <= sidx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg      <= res_next;
        cnt_reg      <= cnt_next;
        out_ev_reg   <= out_ev_next;
        out_id_reg   <= out_id_next;
        out_port_reg <= out_port_next;
        out_hb_reg   <= out_hb_next;
        out_cnt_reg  <= out_cnt_next;
        out_due_reg  <= out_due_next;
        out_last_reg <= out_last_next;
    end

    assign cnt_ext  = {6'd0, out_cnt_reg};
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_ev_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {1'b0, out_due_reg, cnt_ext[5:0], out_hb_reg, out_port_reg, out_id_reg};

    `HMT_ASSERT(a_one_request, accept |=> !s_tready, "request taken while busy")
    `HMT_ASSERT(a_self_valid, valid_vec[0], "self slot lost")
    `HMT_ASSERT(a_add_one_claim, add_commit |-> $onehot(claim_vec), "add without single claim")
    `HMT_ASSERT_NEVER(a_tail_state, tail.active && (state_reg != ST_PASS), "stray probe")

endmodule

`default_nettype wire
